/* design/tllc_pkg.sv */
// Shared widths, register indexes, reset values and pipeline control types.
package tllc_pkg;

  localparam int COORD_W        = 32;
  localparam int SCALE_W        = 48;
  localparam int SCALE_HALF_W   = 24;
  localparam int LVL_W          = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 48;
  localparam int DEF_FULL_LEVEL = 32;

  localparam logic [COORD_W-1:0] MIN_RST       = '0;
  localparam logic [SCALE_W-1:0] SCALE_RST     = 48'd65536;
  localparam logic [LVL_W-1:0]   MIN_LEVEL_RST = 6'd0;
  localparam logic [LVL_W-1:0]   MAX_LEVEL_RST = 6'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X     = 3'd0,
    CFG_MIN_Y     = 3'd1,
    CFG_MIN_Z     = 3'd2,
    CFG_SCALE_X   = 3'd3,
    CFG_SCALE_Y   = 3'd4,
    CFG_SCALE_Z   = 3'd5,
    CFG_MIN_LEVEL = 3'd6,
    CFG_MAX_LEVEL = 3'd7
  } cfg_idx_e;

  // Load enables of the three fraction stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } frac_en_t;

endpackage

/* design/tllc_coord_frac.sv */
// Three-stage grid fraction unit for one coordinate: offset, products, saturate.
module tllc_coord_frac #(
  parameter int FRAC_W = tllc_pkg::DEF_FULL_LEVEL
) (
  input  logic                              clk_i,
  input  tllc_pkg::frac_en_t                en_i,
  input  logic [tllc_pkg::COORD_W-1:0]      pos_i,
  input  logic [tllc_pkg::COORD_W-1:0]      minimum_i,
  input  logic [tllc_pkg::SCALE_W-1:0]      scale_i,
  output logic [FRAC_W-1:0]                 frac_o
);
  import tllc_pkg::*;

  localparam int PROD_W = COORD_W + SCALE_HALF_W;
  localparam int SUM_W  = COORD_W + 9;

  logic [COORD_W:0]        diff;
  logic [COORD_W-1:0]      off_d, off_q;
  logic [PROD_W-1:0]       hi_d, hi_q, lo_d, lo_q;
  logic [SUM_W-1:0]        sum;
  logic                    sat;
  logic [COORD_W-1:0]      frac32;
  logic [FRAC_W-1:0]       frac_d, frac_q;

  // Offset from the box minimum, clamped at zero.
  assign diff  = {pos_i[COORD_W-1], pos_i} - {minimum_i[COORD_W-1], minimum_i};
  assign off_d = diff[COORD_W] ? '0 : diff[COORD_W-1:0];

  // Split 32x48 product into two 32x24 halves.
  assign hi_d = PROD_W'(off_q) * PROD_W'(scale_i[SCALE_W-1:SCALE_HALF_W]);
  assign lo_d = PROD_W'(off_q) * PROD_W'(scale_i[SCALE_HALF_W-1:0]);

  // Recombine as (hi << 8) + (lo >> 16) and saturate to 32 bits.
  assign sum    = SUM_W'({hi_q[SCALE_HALF_W-1:0], 8'd0}) + SUM_W'(lo_q[PROD_W-1:16]);
  assign sat    = (|hi_q[PROD_W-1:SCALE_HALF_W]) || (|sum[SUM_W-1:COORD_W]);
  assign frac32 = sat ? '1 : sum[COORD_W-1:0];
  assign frac_d = frac32[COORD_W-1 -: FRAC_W];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      off_q <= off_d;
    end
    if (en_i.s2) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
    if (en_i.s3) begin
      frac_q <= frac_d;
    end
  end

  assign frac_o = frac_q;

endmodule

/* design/triangle_lod_level_classifier.sv */
// Top level: triangle level-of-detail bucket classifier pipeline.
//
// Classifies one triangle per clock when the output is not stalled. Each
// vertex coordinate is offset from the box minimum (clamped at zero), scaled
// by the per-axis reciprocal box size to a saturating 32-bit grid fraction,
// and the level at which each vertex pair first separates is found. With both
// levels capped at FULL_LEVEL, the bucket is min_level when max_level + 1 <
// min_level, FULL_LEVEL when the worst pair still coincides beyond the larger
// of max_level and min_level, else max(separation, min_level). The pipeline
// is five stages deep, and when nothing stalls one word is taken every cycle
// at steady state. The depth is set by the fraction path (offset, a pair of
// 32x24 multiplies, recombine and saturate), then the leading-one search per
// pair, then the max and bucket select. Every stage carries its own valid bit
// and moves on whenever the stage after it is empty or moving, so bubbles
// collapse and the input keeps flowing while a finished word waits at the
// output, until every stage holds a word; only then is the input stalled.
// Configuration writes are taken every cycle (cfg_ready_o is always high) and
// must only be issued while the pipeline is empty.
module triangle_lod_level_classifier #(
  parameter int FULL_LEVEL = tllc_pkg::DEF_FULL_LEVEL
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tllc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tllc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // triangle input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_a_x_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_a_y_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_a_z_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_b_x_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_b_y_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_b_z_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_c_x_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_c_y_i,
  input  logic [tllc_pkg::COORD_W-1:0]       vert_c_z_i,
  // bucket output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tllc_pkg::LVL_W-1:0]         bucket_level_o
);
  import tllc_pkg::*;

  localparam int NSTG = 5;
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(FULL_LEVEL);
  localparam logic [LVL_W-1:0] NONE_LVL = LVL_W'(FULL_LEVEL + 1);

  // Level of the highest set bit counted from the top, or "never separates".
  function automatic logic [LVL_W-1:0] sep_level(input logic [FULL_LEVEL-1:0] x);
    logic [LVL_W-1:0] lvl;
    lvl = NONE_LVL;
    for (int i = 0; i < FULL_LEVEL; i++) begin
      if (x[i]) lvl = LVL_W'(FULL_LEVEL - i);
    end
    return lvl;
  endfunction

  function automatic logic [LVL_W-1:0] cap_level(input logic [LVL_W-1:0] v);
    return (v > FULL_LVL) ? FULL_LVL : v;
  endfunction

  //--------------------------------------------------------------------------
  // Configuration registers
  //--------------------------------------------------------------------------
  logic [COORD_W-1:0] min_q   [3];
  logic [SCALE_W-1:0] scale_q [3];
  logic [LVL_W-1:0]   min_level_q, max_level_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        min_q[a]   <= MIN_RST;
        scale_q[a] <= SCALE_RST;
      end
      min_level_q <= MIN_LEVEL_RST;
      max_level_q <= MAX_LEVEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_X:     min_q[0]    <= cfg_data_i[COORD_W-1:0];
        CFG_MIN_Y:     min_q[1]    <= cfg_data_i[COORD_W-1:0];
        CFG_MIN_Z:     min_q[2]    <= cfg_data_i[COORD_W-1:0];
        CFG_SCALE_X:   scale_q[0]  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Y:   scale_q[1]  <= cfg_data_i[SCALE_W-1:0];
        CFG_SCALE_Z:   scale_q[2]  <= cfg_data_i[SCALE_W-1:0];
        CFG_MIN_LEVEL: min_level_q <= cfg_data_i[LVL_W-1:0];
        CFG_MAX_LEVEL: max_level_q <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Pipeline control: valid per stage, advance when the next stage frees up
  //--------------------------------------------------------------------------
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] ready;
  logic [NSTG-1:0] load;
  logic [NSTG-1:0] upstream;
  frac_en_t        frac_en;

  assign upstream = {valid_q[NSTG-2:0], in_valid_i};

  always_comb begin
    ready[NSTG-1] = !valid_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  // Load a stage only when a word is coming in from upstream.
  assign load = ready & upstream;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (ready[k]) valid_q[k] <= upstream[k];
      end
    end
  end

  assign in_stall_o = !ready[0];
  assign frac_en    = '{s1: load[0], s2: load[1], s3: load[2]};

  //--------------------------------------------------------------------------
  // Stages 1-3: grid fractions for all nine coordinates
  //--------------------------------------------------------------------------
  logic [COORD_W-1:0]    pos  [3][3];
  logic [FULL_LEVEL-1:0] frac [3][3];

  assign pos[0][0] = vert_a_x_i;
  assign pos[0][1] = vert_a_y_i;
  assign pos[0][2] = vert_a_z_i;
  assign pos[1][0] = vert_b_x_i;
  assign pos[1][1] = vert_b_y_i;
  assign pos[1][2] = vert_b_z_i;
  assign pos[2][0] = vert_c_x_i;
  assign pos[2][1] = vert_c_y_i;
  assign pos[2][2] = vert_c_z_i;

  for (genvar v = 0; v < 3; v++) begin : g_vert
    for (genvar a = 0; a < 3; a++) begin : g_axis
      tllc_coord_frac #(
        .FRAC_W (FULL_LEVEL)
      ) u_frac (
        .clk_i     (clk_i),
        .en_i      (frac_en),
        .pos_i     (pos[v][a]),
        .minimum_i (min_q[a]),
        .scale_i   (scale_q[a]),
        .frac_o    (frac[v][a])
      );
    end
  end

  //--------------------------------------------------------------------------
  // Stage 4: separation level of each vertex pair (ab, ac, bc)
  //--------------------------------------------------------------------------
  logic [FULL_LEVEL-1:0] diff_ab, diff_ac, diff_bc;
  logic [LVL_W-1:0]      sep_d [3];
  logic [LVL_W-1:0]      sep_q [3];

  always_comb begin
    diff_ab = '0;
    diff_ac = '0;
    diff_bc = '0;
    for (int a = 0; a < 3; a++) begin
      diff_ab = diff_ab | (frac[0][a] ^ frac[1][a]);
      diff_ac = diff_ac | (frac[0][a] ^ frac[2][a]);
      diff_bc = diff_bc | (frac[1][a] ^ frac[2][a]);
    end
    sep_d[0] = sep_level(diff_ab);
    sep_d[1] = sep_level(diff_ac);
    sep_d[2] = sep_level(diff_bc);
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      sep_q <= sep_d;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 5: worst pair and bucket select, held in the output register
  //--------------------------------------------------------------------------
  logic [LVL_W-1:0] worst, max01, lo_lvl, hi_lvl, top_lvl, bucket_d, bucket_q;

  always_comb begin
    max01   = (sep_q[1] > sep_q[0]) ? sep_q[1] : sep_q[0];
    worst   = (sep_q[2] > max01) ? sep_q[2] : max01;
    lo_lvl  = cap_level(min_level_q);
    hi_lvl  = cap_level(max_level_q);
    top_lvl = (hi_lvl > lo_lvl) ? hi_lvl : lo_lvl;
    if (({1'b0, hi_lvl} + (LVL_W+1)'(1)) < {1'b0, lo_lvl}) begin
      // inverted range: no sweep step runs
      bucket_d = lo_lvl;
    end else if (worst > top_lvl) begin
      // still degenerate at full detail
      bucket_d = FULL_LVL;
    end else begin
      bucket_d = (worst > lo_lvl) ? worst : lo_lvl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      bucket_q <= bucket_d;
    end
  end

  assign out_valid_o    = valid_q[NSTG-1];
  assign bucket_level_o = bucket_q;

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bucket_level_o <= FULL_LVL))
    else $error("bucket above full level");

  a_bucket_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bucket_level_o != '0))
    else $error("bucket level zero");

  a_bucket_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bucket_level_o >= cap_level(min_level_q)))
    else $error("bucket below min level");

  a_stall_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_q == '1))
    else $error("input stalled with a free stage");

endmodule

/* test/lod_bucket_checker.sv */
// Checker that predicts the level-of-detail bucket of each triangle and compares results.
module lod_bucket_checker #(
  parameter int FULL_LEVEL = tllc_pkg::DEF_FULL_LEVEL
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic [tllc_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [tllc_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_stall_i,
  input  logic [8:0][tllc_pkg::COORD_W-1:0]       corner_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_stall_i,
  input  logic [tllc_pkg::LVL_W-1:0]              bucket_level_i,
  output int                                      pending_o,
  output int                                      mismatch_o
);
  import tllc_pkg::*;

  logic [COORD_W-1:0] box_min [3];
  logic [SCALE_W-1:0] box_scale [3];
  logic [LVL_W-1:0]   lod_floor;
  logic [LVL_W-1:0]   lod_ceiling;

  // Expected buckets in arrival order, indexed by a running write and read count.
  logic [LVL_W-1:0]   bucket_due [int];
  int                 due_wr = 0;
  int                 due_rd = 0;
  logic [LVL_W-1:0]   bucket_want;
  int                 bucket_due_cnt;
  int                 fails = 0;

  assign pending_o  = bucket_due_cnt;
  assign mismatch_o = fails;

  // Offset from the box minimum, clamped at zero, scaled to a saturating 0.32 fraction.
  function automatic logic [31:0] grid_frac(input logic [COORD_W-1:0] pos,
                                            input logic [COORD_W-1:0] base,
                                            input logic [SCALE_W-1:0] scale);
    logic signed [COORD_W:0] offset;
    logic [79:0]             product;
    offset = $signed({pos[COORD_W-1], pos}) - $signed({base[COORD_W-1], base});
    if (offset <= 0) return '0;
    product = {48'b0, offset[COORD_W-1:0]} * {32'b0, scale};
    if (product[79:48] != '0) return '1;
    return product[47:16];
  endfunction

  // First level at which two vertices land in different grid cells.
  function automatic int pair_split(input logic [2:0][31:0] p, input logic [2:0][31:0] q);
    logic [31:0] diff;
    int          lead;
    diff = (p[0] ^ q[0]) | (p[1] ^ q[1]) | (p[2] ^ q[2]);
    lead = 0;
    while (lead < 32 && !diff[31-lead]) lead++;
    if (lead >= FULL_LEVEL) return FULL_LEVEL + 1;
    return lead + 1;
  endfunction

  function automatic logic [LVL_W-1:0] predict_bucket(input logic [8:0][COORD_W-1:0] c);
    logic [2:0][2:0][31:0] frac;
    int                    worst;
    int                    lo;
    int                    hi;
    int                    top;
    for (int v = 0; v < 3; v++)
      for (int a = 0; a < 3; a++)
        frac[v][a] = grid_frac(c[v*3+a], box_min[a], box_scale[a]);
    worst = pair_split(frac[0], frac[1]);
    if (pair_split(frac[0], frac[2]) > worst) worst = pair_split(frac[0], frac[2]);
    if (pair_split(frac[1], frac[2]) > worst) worst = pair_split(frac[1], frac[2]);
    lo  = (int'(lod_floor) > FULL_LEVEL) ? FULL_LEVEL : int'(lod_floor);
    hi  = (int'(lod_ceiling) > FULL_LEVEL) ? FULL_LEVEL : int'(lod_ceiling);
    top = (hi > lo) ? hi : lo;
    // inverted window: the sweep never runs
    if (hi + 1 < lo) return LVL_W'(lo);
    if (worst > top) return LVL_W'(FULL_LEVEL);
    return LVL_W'((worst > lo) ? worst : lo);
  endfunction

  task automatic report_mismatch(input string what, input logic [LVL_W-1:0] got,
                                 input logic [LVL_W-1:0] want);
    $display("%0t: bucket check: %s (got %0d, expected %0d)", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a]   = MIN_RST;
        box_scale[a] = SCALE_RST;
      end
      lod_floor   = MIN_LEVEL_RST;
      lod_ceiling = MAX_LEVEL_RST;
      bucket_due.delete();
      due_wr = 0;
      due_rd = 0;
      bucket_due_cnt <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_X:     box_min[0]   = cfg_data_i[COORD_W-1:0];
          CFG_MIN_Y:     box_min[1]   = cfg_data_i[COORD_W-1:0];
          CFG_MIN_Z:     box_min[2]   = cfg_data_i[COORD_W-1:0];
          CFG_SCALE_X:   box_scale[0] = cfg_data_i[SCALE_W-1:0];
          CFG_SCALE_Y:   box_scale[1] = cfg_data_i[SCALE_W-1:0];
          CFG_SCALE_Z:   box_scale[2] = cfg_data_i[SCALE_W-1:0];
          CFG_MIN_LEVEL: lod_floor    = cfg_data_i[LVL_W-1:0];
          CFG_MAX_LEVEL: lod_ceiling  = cfg_data_i[LVL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        bucket_due[due_wr] = predict_bucket(corner_i);
        due_wr++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_wr == due_rd) begin
          report_mismatch("bucket with no triangle pending", bucket_level_i, '0);
        end else begin
          bucket_want = bucket_due[due_rd];
          bucket_due.delete(due_rd);
          due_rd++;
          if (bucket_level_i !== bucket_want)
            report_mismatch("wrong bucket level", bucket_level_i, bucket_want);
        end
      end
      bucket_due_cnt <= due_wr - due_rd;
    end
  end

endmodule

/* test/tb_top.sv */
// Testbench top: drives triangles and register writes into the classifier, gives the verdict.
module tb_top;
  import tllc_pkg::*;

  // Give up after this many cycles in which no word moves on any channel.
  localparam int QUIET_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int PHASES          = 9;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic [8:0][COORD_W-1:0] corner     = '0;
  logic                   out_stall   = 1'b0;
  logic                   cfg_ready;
  logic                   in_stall;
  logic                   out_valid;
  logic [LVL_W-1:0]       bucket_level;

  int                     pending;
  int                     mismatches;
  int                     idle_pct    = 0;
  int                     stall_pct   = 0;
  int                     quiet_cycles = 0;
  // Box minimum currently programmed; steers the random vertices toward the box.
  logic [COORD_W-1:0]     aim_min [3] = '{default: '0};

  always #4 clk_i = ~clk_i;

  triangle_lod_level_classifier u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .vert_a_x_i     (corner[0]),
    .vert_a_y_i     (corner[1]),
    .vert_a_z_i     (corner[2]),
    .vert_b_x_i     (corner[3]),
    .vert_b_y_i     (corner[4]),
    .vert_b_z_i     (corner[5]),
    .vert_c_x_i     (corner[6]),
    .vert_c_y_i     (corner[7]),
    .vert_c_z_i     (corner[8]),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .bucket_level_o (bucket_level)
  );

  lod_bucket_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .corner_i       (corner),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .bucket_level_i (bucket_level),
    .pending_o      (pending),
    .mismatch_o     (mismatches)
  );

  // Receiver side: stall the output at the rate of the current idling mode.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles with no word moving anywhere; reset on any handshake.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one triangle, idling first at the sender's rate, and hold it until taken.
  task automatic send_triangle(input logic [8:0][COORD_W-1:0] shape);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    corner   <= shape;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Advance until every predicted bucket has come out.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Hold one register write until taken; the caller drops valid after the last one.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  function automatic logic [SCALE_W-1:0] rand_scale();
    return {$urandom, 16'($urandom)} >> $urandom_range(0, 47);
  endfunction

  // Phase 0..2: sender idles lightly, receiver stalls hard; 3..5 the reverse; then none.
  task automatic set_idling(input int phase);
    idle_pct  = (phase < 3) ? 17 : (phase < 6) ? 82 : 0;
    stall_pct = (phase < 3) ? 82 : (phase < 6) ? 17 : 0;
  endtask

  // Write every register for a phase; unused upper data bits carry noise.
  task automatic program_phase(input int phase);
    logic [COORD_W-1:0] mins [3];
    logic [SCALE_W-1:0] scales [3];
    logic [LVL_W-1:0]   lo;
    logic [LVL_W-1:0]   hi;
    for (int a = 0; a < 3; a++) begin
      mins[a]   = $urandom;
      scales[a] = rand_scale();
    end
    lo = LVL_W'($urandom_range(0, 63));
    hi = LVL_W'($urandom_range(0, 63));
    case (phase)
      0: begin
        // full level window over the reset box
        mins   = '{default: '0};
        scales = '{default: SCALE_RST};
        lo = '0;
        hi = 6'd32;
      end
      1: begin
        lo = LVL_W'($urandom_range(0, 12));
        hi = LVL_W'($urandom_range(8, 32));
      end
      2: begin
        // zero scale collapses every vertex; levels beyond full detail
        scales = '{default: '0};
        lo = '0;
        hi = 6'd63;
      end
      3: begin
        // most negative minimum, saturating scale, inverted window
        mins   = '{default: 32'h8000_0000};
        scales = '{default: '1};
        lo = 6'd20;
        hi = 6'd5;
      end
      4: begin
        // most positive minimum clamps nearly everything
        mins = '{default: 32'h7fff_ffff};
        lo = 6'd33;
        hi = 6'd40;
      end
      5: begin
        // min_level just above max_level: the sweep still runs
        for (int a = 0; a < 3; a++) scales[a] = SCALE_RST + SCALE_W'($urandom_range(0, 4096));
        hi = LVL_W'($urandom_range(0, 31));
        lo = hi + 6'd1;
      end
      7: begin
        mins   = '{default: '0};
        scales = '{default: SCALE_W'(1)};
        lo = '0;
        hi = '0;
      end
      default: ;
    endcase
    write_reg(CFG_MIN_X,     {16'($urandom), mins[0]});
    write_reg(CFG_MIN_Y,     {16'($urandom), mins[1]});
    write_reg(CFG_MIN_Z,     {16'($urandom), mins[2]});
    write_reg(CFG_SCALE_X,   scales[0]);
    write_reg(CFG_SCALE_Y,   scales[1]);
    write_reg(CFG_SCALE_Z,   scales[2]);
    write_reg(CFG_MIN_LEVEL, {$urandom, 10'($urandom), lo});
    write_reg(CFG_MAX_LEVEL, {$urandom, 10'($urandom), hi});
    cfg_valid <= 1'b0;
    aim_min = mins;
  endtask

  // Mostly tight triangles near the box, so separations reach deep levels;
  // the rest are scattered vertices or fully coinciding ones.
  task automatic make_triangle(output logic [8:0][COORD_W-1:0] shape);
    int                 pick;
    int                 k;
    logic [COORD_W-1:0] base;
    logic [COORD_W-1:0] mask;
    pick = $urandom_range(99);
    k    = $urandom_range(0, 32);
    mask = (k == 32) ? '1 : ((32'd1 << k) - 32'd1);
    for (int a = 0; a < 3; a++) begin
      base = ($urandom_range(99) < 70) ? aim_min[a] + ($urandom >> $urandom_range(0, 31))
                                       : $urandom;
      shape[a] = base;
      for (int v = 1; v < 3; v++) begin
        if (pick < 10)                    shape[v*3+a] = $urandom;
        else if (pick < 20)               shape[v*3+a] = base;
        else if ($urandom_range(3) == 0)  shape[v*3+a] = base;
        else if ($urandom_range(1) == 1)  shape[v*3+a] = base + ($urandom & mask);
        else                              shape[v*3+a] = base - ($urandom & mask);
      end
    end
  endtask

  initial begin
    logic [8:0][COORD_W-1:0] shape;
    logic [COORD_W-1:0]      flat_vals [5];
    int                      split_bits [5];
    flat_vals  = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0001_0000};
    split_bits = '{30, 20, 19, 11, 0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(0);

    // Directed triangles on the reset box: coinciding vertices at the field extremes,
    // negative positions that clamp to the box corner, then single-bit splits on
    // each axis and pair around the max_level boundary.
    foreach (flat_vals[i]) begin
      shape = {9{flat_vals[i]}};
      send_triangle(shape);
    end
    foreach (split_bits[i]) begin
      shape = {9{32'h0040_0000}};
      shape[(1 + i % 2) * 3 + i % 3] ^= 32'd1 << split_bits[i];
      send_triangle(shape);
    end
    shape = {{3{32'h0000_0000}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}}};
    send_triangle(shape);
    shape = {{3{32'h0000_0001}}, {3{32'h7fff_ffff}}, {3{32'h0000_0000}}};
    send_triangle(shape);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Drain before touching the registers.
      in_valid <= 1'b0;
      wait_drained();
      set_idling(phase);
      program_phase(phase);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          // hold the sender until the pipeline has emptied
          in_valid <= 1'b0;
          wait_drained();
        end
        make_triangle(shape);
        send_triangle(shape);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
